// ===== hdl/tblm_pkg.sv =====
// Shared types, constants and bin decision functions for the livetime bin merger.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tblm_pkg;

	localparam int TW   = 52;          // time field width
	localparam int LW   = 32;          // entry livetime width
	localparam int AW   = 40;          // accumulated livetime width
	localparam int IW   = 32;          // entry index width
	localparam int CFGW = 32;          // configuration word width
	localparam int MW   = 8;           // mode width
	localparam int QW   = 16;          // quality width
	localparam int BSW  = 16;          // bin_seconds width
	localparam int USW  = 20;          // width of the microseconds-per-second constant
	localparam int BUW  = 36;          // bin length in microseconds
	localparam int THW  = 53;          // bin start plus bin length
	localparam int NDW  = 54;          // signed entry duration
	localparam int CW   = 55;          // signed width of the length test
	localparam int RMAX = 4;           // most bins closed by one entry
	localparam int RCW  = 3;           // width of a bin count up to RMAX
	localparam int RIW  = 2;           // index into a batch

	localparam logic [USW-1:0] US_PER_SEC   = USW'(1000000);
	localparam logic [BUW-1:0] BIN_US_RESET = BUW'(30000000);
	localparam logic [AW-1:0]  LIVE_MAX     = '1;

	typedef enum logic [2:0] {
		REASON_LENGTH  = 3'd0,
		REASON_CONFIG  = 3'd1,
		REASON_MODE    = 3'd2,
		REASON_QUALITY = 3'd3,
		REASON_DROP    = 3'd4,
		REASON_RESUME  = 3'd5,
		REASON_END     = 3'd6,
		REASON_NONE    = 3'd7
	} reason_t;

	typedef struct packed {
		logic [TW-1:0]   start;
		logic [TW-1:0]   stop;
		logic [LW-1:0]   live;
		logic [CFGW-1:0] cfg;
		logic [MW-1:0]   mode;
		logic [QW-1:0]   qual;
		logic [THW-1:0]  thr;     // start + bin length
		logic [NDW-1:0]  nd;      // stop - start, two's complement
	} entry_t;

	typedef struct packed {
		logic   valid;
		logic   fin;
		entry_t e;
	} stage_t;

	typedef struct packed {
		logic            is_open;
		logic [TW-1:0]   start;
		logic [THW-1:0]  thr;
		logic [CFGW-1:0] cfg;
		logic [MW-1:0]   mode;
		logic [QW-1:0]   qual;
		logic            ref_live;
		logic [AW-1:0]   acc;
		logic [TW-1:0]   last_stop;
		logic [IW-1:0]   first_idx;
	} bin_t;

	typedef struct packed {
		logic [TW-1:0] bin_start;
		logic [TW-1:0] bin_stop;
		logic [AW-1:0] livetime;
		logic [IW-1:0] first_idx;
		reason_t       reason;
		logic          eor;
	} result_t;

	typedef struct packed {
		logic [RCW-1:0]           n;
		result_t [RMAX-1:0]       r;
	} batch_t;

	typedef struct packed {
		bin_t       st;
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} judge_t;

	function automatic bin_t open_bin(entry_t e, logic [IW-1:0] idx);
		bin_t b;
		b.is_open   = 1'b1;
		b.start     = e.start;
		b.thr       = e.thr;
		b.cfg       = e.cfg;
		b.mode      = e.mode;
		b.qual      = e.qual;
		b.ref_live  = |e.live;
		b.acc       = '0;
		b.last_stop = '0;
		b.first_idx = idx;
		return b;
	endfunction

	function automatic bin_t include_entry(bin_t b, entry_t e);
		bin_t       o;
		logic [AW:0] s;
		o = b;
		s = {1'b0, b.acc} + {{(AW + 1 - LW){1'b0}}, e.live};
		o.acc       = s[AW] ? LIVE_MAX : s[AW-1:0];
		o.last_stop = e.stop;
		return o;
	endfunction

	function automatic result_t make_result(bin_t b, reason_t why);
		result_t r;
		r.bin_start = b.start;
		r.bin_stop  = b.last_stop;
		r.livetime  = b.acc;
		r.first_idx = b.first_idx;
		r.reason    = why;
		r.eor       = 1'b0;
		return r;
	endfunction

	function automatic reason_t change_reason(bin_t b, entry_t e);
		reason_t why;
		if (e.cfg != b.cfg) begin
			why = REASON_CONFIG;
		end else if (e.mode != b.mode) begin
			why = REASON_MODE;
		end else if (e.qual != b.qual) begin
			why = REASON_QUALITY;
		end else if (!(|e.live) && b.ref_live) begin
			why = REASON_DROP;
		end else if ((|e.live) && !b.ref_live) begin
			why = REASON_RESUME;
		end else begin
			why = REASON_NONE;
		end
		return why;
	endfunction

	// Length test: stop + next duration against bin start + bin length.
	function automatic logic length_hit(logic [CW-1:0] lhs, logic [THW-1:0] thr);
		return $signed(lhs) > $signed({{(CW - THW){1'b0}}, thr});
	endfunction

	// Judge one entry against the open bin; nd is the duration of the entry after it.
	function automatic judge_t judge(bin_t s, entry_t e, logic [IW-1:0] idx,
			logic [NDW-1:0] nd);
		judge_t        j;
		bin_t          b;
		reason_t       why;
		logic [CW-1:0] lhs;
		j   = '0;
		b   = s.is_open ? s : open_bin(e, idx);
		lhs = {{(CW - TW){1'b0}}, e.stop} + {{(CW - NDW){nd[NDW-1]}}, nd};
		if (length_hit(lhs, b.thr)) begin
			b         = include_entry(b, e);
			j.r0      = make_result(b, REASON_LENGTH);
			j.n       = 2'd1;
			b.is_open = 1'b0;
		end else begin
			why = change_reason(b, e);
			if (why != REASON_NONE) begin
				// close without this entry, then reopen at it
				j.r0 = make_result(b, why);
				b    = open_bin(e, idx);
				b    = include_entry(b, e);
				if (length_hit(lhs, b.thr)) begin
					j.r1      = make_result(b, REASON_LENGTH);
					j.n       = 2'd2;
					b.is_open = 1'b0;
				end else begin
					j.n = 2'd1;
				end
			end else begin
				b = include_entry(b, e);
			end
		end
		j.st = b;
		return j;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tblm_in_stage.sv =====
// Input register and bin length register for the livetime bin merger.
// Precomputes each entry's duration and bin threshold. Depends on tblm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tblm_in_stage
	import tblm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TW-1:0]          entry_start,
	input  logic [TW-1:0]          entry_stop,
	input  logic [LW-1:0]          entry_livetime,
	input  logic [CFGW-1:0]        config_id,
	input  logic [MW-1:0]          mode_id,
	input  logic signed [QW-1:0]   quality_flag,
	input  logic                   final_entry,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [BSW-1:0]         cfg_data,
	input  logic                   advance,
	output stage_t                 stage_s1
);

	logic [BUW-1:0] bin_us_q;
	entry_t         e_in;
	logic           s1_valid_q;
	logic           s1_fin_s1;
	entry_t         s1_entry_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_us_q <= BIN_US_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bin_us_q <= BUW'(cfg_data) * BUW'(US_PER_SEC);
		end
	end

	always_comb begin
		e_in.start = entry_start;
		e_in.stop  = entry_stop;
		e_in.live  = entry_livetime;
		e_in.cfg   = config_id;
		e_in.mode  = mode_id;
		e_in.qual  = quality_flag;
		e_in.thr   = {1'b0, entry_start} + {{(THW - BUW){1'b0}}, bin_us_q};
		e_in.nd    = {{(NDW - TW){1'b0}}, entry_stop} - {{(NDW - TW){1'b0}}, entry_start};
	end

	assign in_ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_entry_s1 <= e_in;
			s1_fin_s1   <= final_entry;
		end
	end

	assign stage_s1.valid = s1_valid_q;
	assign stage_s1.fin   = s1_fin_s1;
	assign stage_s1.e     = s1_entry_s1;

endmodule

`default_nettype wire

// ===== hdl/tblm_core.sv =====
// Bin decision logic and stream state: judges the held entry, then a final entry.
// Produces a batch of up to four closed bins per entry. Depends on tblm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tblm_core
	import tblm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t stage_s1,
	input  logic   room,
	output logic   advance,
	output batch_t batch
);

	logic           pend_valid_q;
	entry_t         pend_q;
	bin_t           bin_q;
	logic [IW-1:0]  count_q;

	judge_t         ja;
	judge_t         jb;
	logic [RIW-1:0] off;
	logic [RCW-1:0] end_pos;
	logic [RCW-1:0] n_all;
	result_t [RMAX-1:0] res;

	always_comb begin
		if (pend_valid_q) begin
			ja = judge(bin_q, pend_q, count_q - IW'(1), stage_s1.e.nd);
		end else begin
			ja    = '0;
			ja.st = bin_q;
		end
		jb = judge(ja.st, stage_s1.e, count_q, '0);
	end

	always_comb begin
		res     = '0;
		off     = ja.n;
		end_pos = RCW'(ja.n) + RCW'(jb.n);
		n_all   = RCW'(ja.n);
		if (ja.n != 2'd0) begin
			res[0] = ja.r0;
		end
		if (ja.n == 2'd2) begin
			res[1] = ja.r1;
		end
		if (stage_s1.fin) begin
			if (jb.n != 2'd0) begin
				res[off] = jb.r0;
			end
			if (jb.n == 2'd2) begin
				res[off + RIW'(1)] = jb.r1;
			end
			n_all = end_pos;
			if (jb.st.is_open) begin
				res[end_pos[RIW-1:0]] = make_result(jb.st, REASON_END);
				n_all = end_pos + RCW'(1);
			end
			if (n_all != '0) begin
				res[RIW'(n_all - RCW'(1))].eor = 1'b1;
			end
		end
		batch.n = n_all;
		batch.r = res;
	end

	// an entry with no closed bin never waits on the output side
	assign advance = stage_s1.valid && (room || (batch.n == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			bin_q        <= '0;
			count_q      <= '0;
		end else if (advance) begin
			if (stage_s1.fin) begin
				pend_valid_q <= 1'b0;
				bin_q.is_open <= 1'b0;
				count_q      <= '0;
			end else begin
				pend_valid_q <= 1'b1;
				bin_q        <= ja.st;
				count_q      <= count_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (advance && !stage_s1.fin) begin
			pend_q <= stage_s1.e;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tblm_out_bank.sv =====
// Result register bank: holds one batch of closed bins and shifts them out one per transfer.
// Depends on tblm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tblm_out_bank
	import tblm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  batch_t  batch,
	input  logic    advance,
	output logic    room,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t head
);

	logic [RCW-1:0]     cnt_q;
	result_t [RMAX-1:0] slot_q;
	logic               take;
	logic               load;

	assign out_valid = cnt_q != '0;
	assign take      = out_valid && out_ready;
	assign room      = (cnt_q == '0) || ((cnt_q == RCW'(1)) && take);
	assign load      = advance && (batch.n != '0);
	assign head      = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.n;
		end else if (take) begin
			cnt_q <= cnt_q - RCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= batch.r;
		end else if (take) begin
			// shift the remaining bins toward the head
			for (int k = 0; k < RMAX - 1; k++) begin
				slot_q[k] <= slot_q[k + 1];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/time_bin_livetime_merger.sv =====
// Top level of the livetime bin merger: input stage, bin decision core, result bank.
// Depends on tblm_pkg, tblm_in_stage, tblm_core, tblm_out_bank.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   in        | in_valid / in_ready   | entry_start .. final_entry
//   out       | out_valid / out_ready | bin_start .. end_of_run
//   cfg       | cfg_valid / cfg_ready | cfg_data (bin_seconds)
//
// An entry is registered on transfer and judged when the entry after it is registered;
// a final entry is judged at once. Its closed bins are registered in the result bank
// before they reach the output. One entry per cycle while out_ready is high and each
// entry closes at most one bin; an entry closing several bins keeps the next bin-closing
// entry waiting until the bank has sent them all. Entries that close no bin never wait.
// Reset gives bin_seconds 30 and an empty stream. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module time_bin_livetime_merger
	import tblm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TW-1:0]        entry_start,
	input  logic [TW-1:0]        entry_stop,
	input  logic [LW-1:0]        entry_livetime,
	input  logic [CFGW-1:0]      config_id,
	input  logic [MW-1:0]        mode_id,
	input  logic signed [QW-1:0] quality_flag,
	input  logic                 final_entry,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [TW-1:0]        bin_start,
	output logic [TW-1:0]        bin_stop,
	output logic [AW-1:0]        bin_livetime,
	output logic [IW-1:0]        first_entry_index,
	output logic [2:0]           cut_reason,
	output logic                 end_of_run,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [BSW-1:0]       cfg_data
);

	stage_t  stage_s1;
	logic    advance;
	logic    room;
	batch_t  batch;
	result_t head;

	tblm_in_stage u_in_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.entry_start    (entry_start),
		.entry_stop     (entry_stop),
		.entry_livetime (entry_livetime),
		.config_id      (config_id),
		.mode_id        (mode_id),
		.quality_flag   (quality_flag),
		.final_entry    (final_entry),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.advance        (advance),
		.stage_s1       (stage_s1)
	);

	tblm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s1 (stage_s1),
		.room     (room),
		.advance  (advance),
		.batch    (batch)
	);

	tblm_out_bank u_out_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.batch     (batch),
		.advance   (advance),
		.room      (room),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head)
	);

	assign bin_start         = head.bin_start;
	assign bin_stop          = head.bin_stop;
	assign bin_livetime      = head.livetime;
	assign first_entry_index = head.first_idx;
	assign cut_reason        = head.reason;
	assign end_of_run        = head.eor;

endmodule

`default_nettype wire

// ===== hdl/tblm_checker.sv =====
// Port-level checks for the livetime bin merger, bound to the top level.
// Depends on tblm_pkg and time_bin_livetime_merger.
`timescale 1ns / 1ps
`default_nettype none

module tblm_checker
	import tblm_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input logic [TW-1:0] bin_start,
	input logic [2:0]    cut_reason,
	input logic          end_of_run
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_start) && $stable(cut_reason))
		else $error("result changed while stalled");

	// the internal no-cut code never leaves the block
	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cut_reason != REASON_NONE)
		else $error("cut reason out of range");

	// a bin closed by end of stream is always the last of its entry
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cut_reason == REASON_END |-> end_of_run)
		else $error("end-of-stream bin without end_of_run");

endmodule

bind time_bin_livetime_merger tblm_checker u_tblm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.bin_start  (bin_start),
	.cut_reason (cut_reason),
	.end_of_run (end_of_run)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for time_bin_livetime_merger: directed and random entry streams.
// Predicts each merged bin in SystemVerilog and checks the results in order.
// Depends on tblm_pkg and the time_bin_livetime_merger RTL.
`timescale 1ns / 1ps

module tb;
	import tblm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [BSW-1:0] BIN_SECS_RESET = 16'd30;
	localparam logic [TW-1:0] SEC = 52'd1000000;
	localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;
	typedef enum int {STREAM_NORMAL, STREAM_NOISE, STREAM_HEAVY} stream_t;

	typedef struct packed {
		logic [TW-1:0]   start;
		logic [TW-1:0]   stop;
		logic [LW-1:0]   live;
		logic [CFGW-1:0] cfg;
		logic [MW-1:0]   mode;
		logic [QW-1:0]   qual;
		logic            fin;
	} tm_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TW-1:0] entry_start = '0;
	logic [TW-1:0] entry_stop = '0;
	logic [LW-1:0] entry_livetime = '0;
	logic [CFGW-1:0] config_id = '0;
	logic [MW-1:0] mode_id = '0;
	logic signed [QW-1:0] quality_flag = '0;
	logic final_entry = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [TW-1:0] bin_start;
	logic [TW-1:0] bin_stop;
	logic [AW-1:0] bin_livetime;
	logic [IW-1:0] first_entry_index;
	logic [2:0] cut_reason;
	logic end_of_run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [BSW-1:0] cfg_data = '0;

	time_bin_livetime_merger dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.entry_start(entry_start),
		.entry_stop(entry_stop),
		.entry_livetime(entry_livetime),
		.config_id(config_id),
		.mode_id(mode_id),
		.quality_flag(quality_flag),
		.final_entry(final_entry),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bin_start(bin_start),
		.bin_stop(bin_stop),
		.bin_livetime(bin_livetime),
		.first_entry_index(first_entry_index),
		.cut_reason(cut_reason),
		.end_of_run(end_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	tm_entry_t entry_q[$];
	result_t bins_due[$];
	tm_entry_t offered;
	idle_t idle_mode = IDLE_NONE;
	int mismatches = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_arm = 1'b0;
	result_t got;
	result_t want;

	// Predictor state
	logic [BSW-1:0] bin_secs = BIN_SECS_RESET;
	bit held_valid = 1'b0;
	tm_entry_t held = '0;
	bit open_now = 1'b0;
	logic [TW-1:0] open_start = '0;
	logic [CFGW-1:0] ref_cfg = '0;
	logic [MW-1:0] ref_mode = '0;
	logic [QW-1:0] ref_qual = '0;
	bit ref_live = 1'b0;
	logic [AW-1:0] live_sum = '0;
	logic [TW-1:0] last_stop = '0;
	logic [IW-1:0] next_index = '0;
	logic [IW-1:0] open_index = '0;
	int new_bins;

	function automatic bit skip_cycle(bit receiver);
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (idle_mode == IDLE_BOTH)
			return roll < 25;
		if (receiver)
			return idle_mode == IDLE_RECV && roll < 61;
		return idle_mode == IDLE_SEND && roll < 61;
	endfunction

	task automatic close_bin(reason_t why);
		result_t r;
		r.bin_start = open_start;
		r.bin_stop = last_stop;
		r.livetime = live_sum;
		r.first_idx = open_index;
		r.reason = why;
		r.eor = 1'b0;
		bins_due.push_back(r);
		new_bins++;
		open_now = 1'b0;
	endtask

	task automatic take_entry(tm_entry_t e);
		logic [AW:0] s;
		s = {1'b0, live_sum} + (AW + 1)'(e.live);
		live_sum = s[AW] ? '1 : s[AW-1:0];
		last_stop = e.stop;
	endtask

	// Judge one entry against the open bin; nstart/nstop belong to the entry after it.
	task automatic judge_entry(tm_entry_t e, logic [IW-1:0] idx, logic [TW-1:0] nstart,
			logic [TW-1:0] nstop);
		logic [63:0] lhs;
		logic [63:0] rhs;
		reason_t why;
		bit settled;
		settled = 1'b0;
		while (!settled) begin
			if (!open_now) begin
				open_now = 1'b1;
				open_start = e.start;
				ref_cfg = e.cfg;
				ref_mode = e.mode;
				ref_qual = e.qual;
				ref_live = e.live != '0;
				live_sum = '0;
				last_stop = '0;
				open_index = idx;
			end
			lhs = 64'(e.stop) + 64'(nstop);
			rhs = 64'(open_start) + 64'(bin_secs) * 64'(US_PER_SEC) + 64'(nstart);
			if (e.cfg != ref_cfg)
				why = REASON_CONFIG;
			else if (e.mode != ref_mode)
				why = REASON_MODE;
			else if (e.qual != ref_qual)
				why = REASON_QUALITY;
			else if (e.live == '0 && ref_live)
				why = REASON_DROP;
			else if (e.live != '0 && !ref_live)
				why = REASON_RESUME;
			else
				why = REASON_NONE;
			if (lhs > rhs) begin
				take_entry(e);
				close_bin(REASON_LENGTH);
				settled = 1'b1;
			end else if (why != REASON_NONE) begin
				// close without this entry; the next pass reopens at it
				close_bin(why);
			end else begin
				take_entry(e);
				settled = 1'b1;
			end
		end
	endtask

	task automatic merge_entry(tm_entry_t e);
		logic [IW-1:0] idx;
		result_t tail;
		idx = next_index;
		next_index = idx + 1;
		new_bins = 0;
		if (held_valid)
			judge_entry(held, idx - 1, e.start, e.stop);
		if (e.fin) begin
			judge_entry(e, idx, '0, '0);
			if (open_now)
				close_bin(REASON_END);
			if (new_bins != 0) begin
				tail = bins_due.pop_back();
				tail.eor = 1'b1;
				bins_due.push_back(tail);
			end
			held_valid = 1'b0;
			next_index = '0;
		end else begin
			held = e;
			held_valid = 1'b1;
		end
	endtask

	task automatic note_mismatch(string what, result_t exp_bin, result_t act_bin);
		if (mismatches < 10)
			$display("%0s: want %h %h %h %h %0d %b, got %h %h %h %h %0d %b",
				what, exp_bin.bin_start, exp_bin.bin_stop, exp_bin.livetime,
				exp_bin.first_idx, exp_bin.reason, exp_bin.eor, act_bin.bin_start,
				act_bin.bin_stop, act_bin.livetime, act_bin.first_idx, act_bin.reason,
				act_bin.eor);
		mismatches++;
	endtask

	// Driver: predict on transfer, then offer the next entry.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				merge_entry(offered);
			if (!in_valid || in_ready) begin
				if (entry_q.size() != 0 && !skip_cycle(1'b0)) begin
					offered = entry_q.pop_front();
					in_valid <= 1'b1;
					entry_start <= offered.start;
					entry_stop <= offered.stop;
					entry_livetime <= offered.live;
					config_id <= offered.cfg;
					mode_id <= offered.mode;
					quality_flag <= offered.qual;
					final_entry <= offered.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each transferred bin against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.bin_start = bin_start;
				got.bin_stop = bin_stop;
				got.livetime = bin_livetime;
				got.first_idx = first_entry_index;
				got.reason = reason_t'(cut_reason);
				got.eor = end_of_run;
				if (bins_due.size() == 0) begin
					note_mismatch("unexpected bin", '0, got);
				end else begin
					want = bins_due.pop_front();
					if (got.bin_start !== want.bin_start || got.bin_stop !== want.bin_stop ||
							got.livetime !== want.livetime ||
							got.first_idx !== want.first_idx ||
							got.reason !== want.reason || got.eor !== want.eor)
						note_mismatch("bin mismatch", want, got);
				end
			end
			out_ready <= (hold_left == 0) && !skip_cycle(1'b1);
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_arm)
			hold_left <= HOLD_CYCLES;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic push_entry(logic [TW-1:0] start, logic [TW-1:0] stop, logic [LW-1:0] live,
			logic [CFGW-1:0] cfg, logic [MW-1:0] mode, logic [QW-1:0] qual, logic fin);
		tm_entry_t e;
		e.start = start;
		e.stop = stop;
		e.live = live;
		e.cfg = cfg;
		e.mode = mode;
		e.qual = qual;
		e.fin = fin;
		entry_q.push_back(e);
	endtask

	task automatic queue_stream(int count, int unsigned dur_max, stream_t kind, bit closes);
		tm_entry_t e;
		logic [TW-1:0] t;
		logic [CFGW-1:0] cfg;
		logic [MW-1:0] mode;
		logic [QW-1:0] qual;
		bit live_on;
		int unsigned d;
		int unsigned pick;
		int i;
		t = TW'({$urandom(), $urandom()});
		cfg = $urandom();
		mode = MW'($urandom());
		qual = QW'($urandom());
		live_on = 1'b1;
		for (i = 0; i < count; i++) begin
			d = $urandom_range(dur_max, 0);
			pick = $urandom_range(99, 0);
			if (kind == STREAM_HEAVY) begin
				e.live = LW'($urandom()) | 32'hF000_0000;
			end else begin
				if (pick < 4)
					cfg = $urandom();
				else if (pick < 8)
					mode = MW'($urandom());
				else if (pick < 12)
					qual = QW'($urandom());
				else if (pick < 20)
					live_on = !live_on;
				if (!live_on)
					e.live = '0;
				else if ($urandom_range(3, 0) == 0)
					e.live = $urandom();
				else
					e.live = LW'(d);
			end
			e.start = t;
			e.stop = ($urandom_range(19, 0) == 0) ? t - TW'(d) : t + TW'(d);
			e.cfg = cfg;
			e.mode = mode;
			e.qual = qual;
			e.fin = closes && (i == count - 1);
			if (kind == STREAM_NOISE) begin
				e.start = TW'({$urandom(), $urandom()});
				e.stop = TW'({$urandom(), $urandom()});
				e.live = ($urandom_range(3, 0) == 0) ? '0 : LW'($urandom());
				e.cfg = $urandom_range(1, 0);
				e.mode = MW'($urandom_range(1, 0));
				e.qual = QW'($urandom_range(1, 0));
				e.fin = e.fin || ($urandom_range(7, 0) == 0);
			end
			entry_q.push_back(e);
			t = e.stop + (($urandom_range(2, 0) == 0) ? TW'($urandom_range(5000, 0)) : '0);
		end
	endtask

	task automatic queue_streams(int total, int unsigned dur_max, int noise_pct);
		int done;
		int n;
		done = 0;
		while (done < total) begin
			n = $urandom_range(20, 3);
			queue_stream(n, dur_max,
				($urandom_range(99, 0) < noise_pct) ? STREAM_NOISE : STREAM_NORMAL, 1'b1);
			done += n;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (entry_q.size() != 0 || in_valid || bins_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_bin_seconds(logic [BSW-1:0] secs);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= secs;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		bin_secs = secs;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset bin length: every kind of early cut, then end of stream
		push_entry('0, SEC, LW'(SEC), 32'h0, 8'h00, 16'h0000, 1'b0);
		push_entry(SEC, 2 * SEC, LW'(SEC), 32'hFFFF_FFFF, 8'h00, 16'h0000, 1'b0);
		push_entry(2 * SEC, 3 * SEC, LW'(SEC), 32'hFFFF_FFFF, 8'hFF, 16'h0000, 1'b0);
		push_entry(3 * SEC, 4 * SEC, LW'(SEC), 32'hFFFF_FFFF, 8'hFF, 16'h8000, 1'b0);
		push_entry(4 * SEC, 5 * SEC, 32'h0, 32'hFFFF_FFFF, 8'hFF, 16'h8000, 1'b0);
		push_entry(5 * SEC, 6 * SEC, 32'h0, 32'hFFFF_FFFF, 8'hFF, 16'h8000, 1'b0);
		push_entry(6 * SEC, 7 * SEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'h8000, 1'b0);
		push_entry(7 * SEC, 8 * SEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'h7FFF, 1'b1);
		// Lone final entry at the top of the time range
		push_entry(TIME_MAX, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1);
		// Negative duration held entry; the final entry is cut and then hits the length
		push_entry(100 * SEC, 101 * SEC, LW'(SEC), 32'h1, 8'h00, 16'h0000, 1'b0);
		push_entry(101 * SEC, 61 * SEC, LW'(SEC), 32'h2, 8'h00, 16'h0000, 1'b0);
		push_entry(61 * SEC, 101 * SEC, LW'(SEC), 32'h3, 8'h00, 16'h0000, 1'b1);
		// Final entry longer than the bin
		push_entry('0, 50 * SEC, 32'd50000000, 32'h7, 8'h00, 16'h0000, 1'b1);
		// Length test exactly at the boundary, then a real hit
		push_entry('0, 10 * SEC, 32'd10, 32'h9, 8'h01, 16'h0001, 1'b0);
		push_entry(10 * SEC, 20 * SEC, 32'd10, 32'h9, 8'h01, 16'h0001, 1'b0);
		push_entry(20 * SEC, 30 * SEC, 32'd10, 32'h9, 8'h01, 16'h0001, 1'b0);
		push_entry(30 * SEC, 40 * SEC, 32'd10, 32'h9, 8'h01, 16'h0001, 1'b1);
		drain();

		// Zero bin length
		idle_mode = IDLE_SEND;
		write_bin_seconds(16'd0);
		queue_streams(30, 2000000, 10);
		drain();

		// Short bins with a long receiver hold-off so the input backs up
		idle_mode = IDLE_RECV;
		write_bin_seconds(16'd1);
		queue_streams(50, 600000, 10);
		@(negedge clk);
		hold_arm = 1'b1;
		wait (hold_left != 0);
		hold_arm = 1'b0;
		drain();

		// Longest bin: large livetimes gathered in one long bin
		idle_mode = IDLE_BOTH;
		write_bin_seconds(16'hFFFF);
		queue_stream(20, 3, STREAM_HEAVY, 1'b1);
		queue_streams(10, 2000000, 0);
		drain();

		// Sender pauses mid-stream until every bin so far has come out
		idle_mode = IDLE_NONE;
		write_bin_seconds(16'd2);
		queue_stream(10, 1000000, STREAM_NORMAL, 1'b0);
		drain();
		queue_stream(10, 1000000, STREAM_NORMAL, 1'b1);
		drain();

		idle_mode = IDLE_BOTH;
		write_bin_seconds(16'd5);
		queue_streams(30, 2000000, 25);
		drain();

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
